[sv/dces_pkg.sv]
package dces_pkg;

   localparam int unsigned NumSignals   = 16;
   localparam int unsigned NumProcesses = 16;
   localparam int unsigned NumMaps      = 16;
   localparam int unsigned NumWaiters   = 8;
   localparam int unsigned WaiterDepth  = NumSignals * NumWaiters;

   localparam logic [31:0] NeverTime = 32'hFFFF_FFFF;
   localparam logic [31:0] StopReset = 32'd50000000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_FINISHED = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef enum logic [3:0] {
      ACT_NEW_SIGNAL  = 4'd0,
      ACT_NEW_PROCESS = 4'd1,
      ACT_NEW_MAP     = 4'd2,
      ACT_WAVEFORM    = 4'd3,
      ACT_WAIT        = 4'd4,
      ACT_WAKE        = 4'd5,
      ACT_TRIGGER     = 4'd6,
      ACT_READ        = 4'd7,
      ACT_TIME        = 4'd8,
      ACT_START       = 4'd9,
      ACT_DELTA       = 4'd10,
      ACT_ADVANCE     = 4'd11
   } action_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_EXEC,
      OP_START_INIT,
      OP_CLR_EVENT,
      OP_APPLY,
      OP_MINP,
      OP_MINS,
      OP_SET_NOW,
      OP_SPRD_A,
      OP_SPRD_B,
      OP_GATHER_INIT,
      OP_GWAKE,
      OP_WAIT_RD,
      OP_WAIT_USE,
      OP_START_LIST,
      OP_EMIT_LIST,
      OP_EMIT_STATUS
   } op_type;

   typedef struct packed {
      logic [3:0]         action;
      logic [3:0]         signal_index;
      logic [3:0]         target_signal;
      logic [3:0]         process_index;
      logic signed [63:0] data_value;
      logic [31:0]        delay;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         new_index;
      logic signed [63:0] read_value;
      logic [31:0]        current_time;
      logic [3:0]         run_process;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] idx;
      logic [2:0] wsel;
      logic [1:0] code;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [4:0] sig_cnt;
      logic [4:0] proc_cnt;
      logic [4:0] map_cnt;
      logic [4:0] run_cnt;
      logic [3:0] wcnt;
      logic       event_flag;
      logic       moved;
      logic       finished;
   } stat_type;

endpackage

[sv/dces_ram.sv]
module dces_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/dces_dp.sv]
module dces_dp import dces_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  req_type     req_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output rsp_type     rsp_item
);

   // signal tables
   logic [63:0] sv_ff   [NumSignals];
   logic        ev_ff   [NumSignals];
   logic        pend_ff [NumSignals];
   logic [31:0] pt_ff   [NumSignals];
   logic [63:0] pv_ff   [NumSignals];
   logic [3:0]  wc_ff   [NumSignals];
   // process tables
   logic [31:0] wake_ff [NumProcesses];
   logic        ton_ff  [NumProcesses];
   logic [3:0]  tsig_ff [NumProcesses];
   logic [63:0] tval_ff [NumProcesses];
   logic        inrun_ff [NumProcesses];
   logic [3:0]  list_ff [NumProcesses];
   // map table
   logic [3:0]  msrc_ff [NumMaps];
   logic [3:0]  mdst_ff [NumMaps];

   req_type     req_ff, req_in;
   logic [4:0]  scnt_ff, scnt_in, pcnt_ff, pcnt_in, mcnt_ff, mcnt_in, ncnt_ff, ncnt_in;
   logic [31:0] now_ff, now_in, stop_ff, stop_in, nt_ff, nt_in;
   logic [63:0] tmp_ff, tmp_in;
   logic        moved_ff, moved_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        sv_we;
   logic [3:0]  sv_waddr;
   logic [63:0] sv_wdata;
   logic        ev_clr_all, ev_we, ev_wdata;
   logic [3:0]  ev_waddr;
   logic        pend_we, pend_wdata, pval_we;
   logic [3:0]  pend_waddr;
   logic [31:0] pt_wdata;
   logic [63:0] pv_wdata;
   logic        wc_we;
   logic [3:0]  wc_waddr, wc_wdata;
   logic        wake_we;
   logic [3:0]  wake_waddr;
   logic [31:0] wake_wdata;
   logic        trig_we, ton_wdata;
   logic [3:0]  trig_waddr, tsig_wdata;
   logic [63:0] tval_wdata;
   logic        map_we;
   logic        inrun_clr_all, app_we;
   logic [3:0]  app_p;
   logic        ram_we;
   logic [6:0]  ram_waddr, ram_raddr;
   logic [3:0]  ram_wdata, ram_rdata;

   logic [3:0]  sv_raddr, wc_raddr, tr_raddr;
   logic [63:0] sv_rd;
   logic [3:0]  wc_rd;
   logic        sig_ok, proc_ok, ti_ok, fire;

   dces_ram #(
      .Width(4),
      .Depth(WaiterDepth)
   ) u_waiters (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (cmd.op)
         OP_EXEC:   sv_raddr = req_ff.signal_index;
         OP_SPRD_A: sv_raddr = msrc_ff[cmd.idx];
         OP_SPRD_B: sv_raddr = mdst_ff[cmd.idx];
         default:   sv_raddr = cmd.idx;
      endcase
   end

   assign wc_raddr = (cmd.op == OP_EXEC) ? req_ff.signal_index : cmd.idx;
   assign tr_raddr = (cmd.op == OP_WAIT_USE) ? ram_rdata : cmd.idx;
   assign sv_rd    = sv_ff[sv_raddr];
   assign wc_rd    = wc_ff[wc_raddr];

   assign sig_ok  = {1'b0, req_ff.signal_index} < scnt_ff;
   assign ti_ok   = {1'b0, req_ff.target_signal} < scnt_ff;
   assign proc_ok = {1'b0, req_ff.process_index} < pcnt_ff;

   assign fire = ton_ff[tr_raddr]
      ? (tsig_ff[tr_raddr] == cmd.idx && sv_rd == tval_ff[tr_raddr]) : 1'b1;

   always_comb begin
      req_in       = req_ff;
      scnt_in      = scnt_ff;
      pcnt_in      = pcnt_ff;
      mcnt_in      = mcnt_ff;
      ncnt_in      = ncnt_ff;
      now_in       = now_ff;
      nt_in        = nt_ff;
      tmp_in       = tmp_ff;
      moved_in     = moved_ff;
      stop_in      = (csr_valid && csr_ready) ? csr_data : stop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      sv_we = 1'b0;  sv_waddr = cmd.idx;  sv_wdata = pv_ff[cmd.idx];
      ev_clr_all = 1'b0;  ev_we = 1'b0;  ev_waddr = cmd.idx;  ev_wdata = 1'b1;
      pend_we = 1'b0;  pend_waddr = cmd.idx;  pend_wdata = 1'b0;  pval_we = 1'b0;
      pt_wdata = '0;  pv_wdata = '0;
      wc_we = 1'b0;  wc_waddr = req_ff.signal_index;  wc_wdata = '0;
      wake_we = 1'b0;  wake_waddr = cmd.idx;  wake_wdata = NeverTime;
      trig_we = 1'b0;  trig_waddr = req_ff.process_index;  ton_wdata = 1'b0;
      tsig_wdata = '0;  tval_wdata = '0;
      map_we = 1'b0;
      inrun_clr_all = 1'b0;  app_we = 1'b0;  app_p = cmd.idx;
      ram_we = 1'b0;
      ram_waddr = {req_ff.signal_index, wc_rd[2:0]};
      ram_wdata = req_ff.process_index;
      ram_raddr = {cmd.idx, cmd.wsel};

      case (cmd.op)
         OP_LATCH: begin
            req_in = req_item;
            nt_in  = NeverTime;
         end
         OP_EXEC: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = ST_OK;
            rsp_in.new_index    = '0;
            rsp_in.read_value   = '0;
            rsp_in.current_time = now_ff;
            rsp_in.run_process  = '0;
            rsp_in.last         = 1'b1;
            case (action_type'(req_ff.action))
               ACT_NEW_SIGNAL: begin
                  if (scnt_ff >= 5'(NumSignals)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     sv_we      = 1'b1;
                     sv_waddr   = scnt_ff[3:0];
                     sv_wdata   = req_ff.data_value;
                     ev_we      = 1'b1;
                     ev_waddr   = scnt_ff[3:0];
                     ev_wdata   = 1'b0;
                     pend_we    = 1'b1;
                     pval_we    = 1'b1;
                     pend_waddr = scnt_ff[3:0];
                     wc_we      = 1'b1;
                     wc_waddr   = scnt_ff[3:0];
                     rsp_in.new_index = scnt_ff[3:0];
                     scnt_in    = scnt_ff + 5'd1;
                  end
               end
               ACT_NEW_PROCESS: begin
                  if (pcnt_ff >= 5'(NumProcesses)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     wake_we    = 1'b1;
                     wake_waddr = pcnt_ff[3:0];
                     trig_we    = 1'b1;
                     trig_waddr = pcnt_ff[3:0];
                     rsp_in.new_index = pcnt_ff[3:0];
                     pcnt_in    = pcnt_ff + 5'd1;
                  end
               end
               ACT_NEW_MAP: begin
                  if (mcnt_ff >= 5'(NumMaps)) begin
                     rsp_in.status = ST_FULL;
                  end else if (sig_ok && ti_ok) begin
                     map_we  = 1'b1;
                     mcnt_in = mcnt_ff + 5'd1;
                  end
               end
               ACT_WAVEFORM: begin
                  if (sig_ok) begin
                     pend_we    = 1'b1;
                     pval_we    = 1'b1;
                     pend_waddr = req_ff.signal_index;
                     pend_wdata = 1'b1;
                     pt_wdata   = now_ff + req_ff.delay;
                     pv_wdata   = req_ff.data_value;
                  end
               end
               ACT_WAIT: begin
                  if (sig_ok && proc_ok) begin
                     if (wc_rd >= 4'(NumWaiters)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        wc_we    = 1'b1;
                        wc_wdata = wc_rd + 4'd1;
                     end
                  end
               end
               ACT_WAKE: begin
                  if (proc_ok) begin
                     wake_we    = 1'b1;
                     wake_waddr = req_ff.process_index;
                     wake_wdata = now_ff + req_ff.delay;
                  end
               end
               ACT_TRIGGER: begin
                  if (proc_ok && sig_ok) begin
                     trig_we    = 1'b1;
                     ton_wdata  = 1'b1;
                     tsig_wdata = req_ff.signal_index;
                     tval_wdata = req_ff.data_value;
                  end
               end
               ACT_READ: begin
                  if (sig_ok) begin
                     rsp_in.read_value = sv_rd;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_START_INIT: begin
            now_in  = '0;
            ncnt_in = '0;
         end
         OP_CLR_EVENT: ev_clr_all = 1'b1;
         OP_APPLY: begin
            if (pend_ff[cmd.idx] && pt_ff[cmd.idx] == now_ff) begin
               pend_we = 1'b1;
               if (pv_ff[cmd.idx] != sv_rd) begin
                  sv_we = 1'b1;
                  ev_we = 1'b1;
               end
            end
         end
         OP_MINP: begin
            if (wake_ff[cmd.idx] < nt_ff) begin
               nt_in = wake_ff[cmd.idx];
            end
         end
         OP_MINS: begin
            if (pend_ff[cmd.idx] && pt_ff[cmd.idx] < nt_ff) begin
               nt_in = pt_ff[cmd.idx];
            end
         end
         OP_SET_NOW: now_in = nt_ff;
         OP_SPRD_A: begin
            tmp_in = sv_rd;
            if (cmd.idx == '0) begin
               moved_in = 1'b0;
            end
         end
         OP_SPRD_B: begin
            if (sv_rd != tmp_ff) begin
               sv_we    = 1'b1;
               sv_waddr = mdst_ff[cmd.idx];
               sv_wdata = tmp_ff;
               ev_we    = 1'b1;
               ev_waddr = mdst_ff[cmd.idx];
               moved_in = 1'b1;
            end
         end
         OP_GATHER_INIT: begin
            inrun_clr_all = 1'b1;
            ncnt_in       = '0;
         end
         OP_GWAKE: begin
            if (wake_ff[cmd.idx] == now_ff) begin
               wake_we = 1'b1;
               if (!inrun_ff[cmd.idx]) begin
                  app_we = 1'b1;
               end
            end
         end
         OP_WAIT_USE: begin
            app_p = ram_rdata;
            if ({1'b0, ram_rdata} < pcnt_ff && fire && !inrun_ff[ram_rdata]) begin
               app_we = 1'b1;
            end
         end
         OP_START_LIST: begin
            if (!ton_ff[cmd.idx]) begin
               app_we = 1'b1;
            end
         end
         OP_EMIT_LIST: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = ST_OK;
            rsp_in.new_index    = '0;
            rsp_in.read_value   = '0;
            rsp_in.current_time = now_ff;
            rsp_in.run_process  = list_ff[cmd.idx];
            rsp_in.last         = cmd.last;
         end
         OP_EMIT_STATUS: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = cmd.code;
            rsp_in.new_index    = '0;
            rsp_in.read_value   = '0;
            rsp_in.current_time = now_ff;
            rsp_in.run_process  = '0;
            rsp_in.last         = 1'b1;
         end
         default: begin
         end
      endcase

      if (app_we) begin
         ncnt_in = ncnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scnt_ff      <= '0;
         pcnt_ff      <= '0;
         mcnt_ff      <= '0;
         ncnt_ff      <= '0;
         now_ff       <= '0;
         stop_ff      <= StopReset;
         moved_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumProcesses; i++) begin
            inrun_ff[i] <= 1'b0;
         end
      end else begin
         scnt_ff      <= scnt_in;
         pcnt_ff      <= pcnt_in;
         mcnt_ff      <= mcnt_in;
         ncnt_ff      <= ncnt_in;
         now_ff       <= now_in;
         stop_ff      <= stop_in;
         moved_ff     <= moved_in;
         rsp_valid_ff <= rsp_valid_in;
         if (inrun_clr_all) begin
            for (int i = 0; i < NumProcesses; i++) begin
               inrun_ff[i] <= 1'b0;
            end
         end else if (app_we) begin
            inrun_ff[app_p] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      nt_ff  <= nt_in;
      tmp_ff <= tmp_in;
      rsp_ff <= rsp_in;
      if (sv_we) begin
         sv_ff[sv_waddr] <= sv_wdata;
      end
      if (ev_clr_all) begin
         for (int i = 0; i < NumSignals; i++) begin
            ev_ff[i] <= 1'b0;
         end
      end else if (ev_we) begin
         ev_ff[ev_waddr] <= ev_wdata;
      end
      if (pend_we) begin
         pend_ff[pend_waddr] <= pend_wdata;
      end
      if (pval_we) begin
         pt_ff[pend_waddr] <= pt_wdata;
         pv_ff[pend_waddr] <= pv_wdata;
      end
      if (wc_we) begin
         wc_ff[wc_waddr] <= wc_wdata;
      end
      if (wake_we) begin
         wake_ff[wake_waddr] <= wake_wdata;
      end
      if (trig_we) begin
         ton_ff[trig_waddr]  <= ton_wdata;
         tsig_ff[trig_waddr] <= tsig_wdata;
         tval_ff[trig_waddr] <= tval_wdata;
      end
      if (map_we) begin
         msrc_ff[mcnt_ff[3:0]] <= req_ff.signal_index;
         mdst_ff[mcnt_ff[3:0]] <= req_ff.target_signal;
      end
      if (app_we) begin
         list_ff[ncnt_ff[3:0]] <= app_p;
      end
   end

   assign stat.sig_cnt    = scnt_ff;
   assign stat.proc_cnt   = pcnt_ff;
   assign stat.map_cnt    = mcnt_ff;
   assign stat.run_cnt    = ncnt_ff;
   assign stat.wcnt       = wc_rd;
   assign stat.event_flag = ev_ff[cmd.idx];
   assign stat.moved      = moved_ff;
   assign stat.finished   = (nt_ff == NeverTime) || (nt_ff > stop_ff);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[sv/dces_ctrl.sv]
module dces_ctrl import dces_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [3:0] start_action,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [17:0] {
      S_IDLE    = 18'h00001,
      S_EXEC    = 18'h00002,
      S_START0  = 18'h00004,
      S_DELTA0  = 18'h00008,
      S_APPLY   = 18'h00010,
      S_MINP    = 18'h00020,
      S_MINS    = 18'h00040,
      S_ADVCHK  = 18'h00080,
      S_SPRDA   = 18'h00100,
      S_SPRDB   = 18'h00200,
      S_SPRDEND = 18'h00400,
      S_SLIST   = 18'h00800,
      S_GINIT   = 18'h01000,
      S_GWAKE   = 18'h02000,
      S_GSIG    = 18'h04000,
      S_GWADDR  = 18'h08000,
      S_GWDATA  = 18'h10000,
      S_EMIT    = 18'h20000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] idx_ff, idx_in, pass_ff, pass_in;
   logic [2:0] w_ff, w_in;
   logic       ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pass_in  = pass_ff;
      w_in     = w_ff;
      ret_in   = ret_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = idx_ff[3:0];
      cmd.wsel = w_ff;
      cmd.code = ST_OK;
      cmd.last = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               idx_in = '0;
               case (action_type'(start_action))
                  ACT_START:   state_in = S_START0;
                  ACT_DELTA:   state_in = S_DELTA0;
                  ACT_ADVANCE: state_in = S_MINP;
                  default:     state_in = S_EXEC;
               endcase
            end
         end
         S_EXEC: begin
            cmd.op   = OP_EXEC;
            state_in = S_IDLE;
         end
         S_START0: begin
            cmd.op   = OP_START_INIT;
            ret_in   = 1'b1;
            pass_in  = '0;
            idx_in   = '0;
            state_in = S_SPRDA;
         end
         S_DELTA0: begin
            cmd.op   = OP_CLR_EVENT;
            idx_in   = '0;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (idx_ff < stat.sig_cnt) begin
               cmd.op = OP_APPLY;
               idx_in = idx_ff + 5'd1;
            end else begin
               idx_in   = '0;
               pass_in  = '0;
               ret_in   = 1'b0;
               state_in = S_SPRDA;
            end
         end
         S_SPRDA: begin
            if (idx_ff < stat.map_cnt) begin
               cmd.op   = OP_SPRD_A;
               state_in = S_SPRDB;
            end else begin
               state_in = S_SPRDEND;
            end
         end
         S_SPRDB: begin
            cmd.op   = OP_SPRD_B;
            idx_in   = idx_ff + 5'd1;
            state_in = S_SPRDA;
         end
         S_SPRDEND: begin
            idx_in = '0;
            // another pass only while values still move, bounded by NumMaps passes
            if (stat.moved && stat.map_cnt != '0 && pass_ff < 5'(NumMaps - 1)) begin
               pass_in  = pass_ff + 5'd1;
               state_in = S_SPRDA;
            end else begin
               state_in = ret_ff ? S_SLIST : S_GINIT;
            end
         end
         S_SLIST: begin
            if (idx_ff < stat.proc_cnt) begin
               cmd.op = OP_START_LIST;
               idx_in = idx_ff + 5'd1;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_GINIT: begin
            cmd.op   = OP_GATHER_INIT;
            idx_in   = '0;
            state_in = S_GWAKE;
         end
         S_GWAKE: begin
            if (idx_ff < stat.proc_cnt) begin
               cmd.op = OP_GWAKE;
               idx_in = idx_ff + 5'd1;
            end else begin
               idx_in   = '0;
               state_in = S_GSIG;
            end
         end
         S_GSIG: begin
            if (idx_ff < stat.sig_cnt) begin
               if (stat.event_flag && stat.wcnt != '0) begin
                  w_in     = '0;
                  state_in = S_GWADDR;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end else begin
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_GWADDR: begin
            cmd.op   = OP_WAIT_RD;
            state_in = S_GWDATA;
         end
         S_GWDATA: begin
            cmd.op = OP_WAIT_USE;
            if (({1'b0, w_ff} + 4'd1) < stat.wcnt) begin
               w_in     = w_ff + 3'd1;
               state_in = S_GWADDR;
            end else begin
               idx_in   = idx_ff + 5'd1;
               state_in = S_GSIG;
            end
         end
         S_EMIT: begin
            if (stat.run_cnt == '0) begin
               cmd.op   = OP_EMIT_STATUS;
               cmd.code = ST_EMPTY;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_EMIT_LIST;
               cmd.last = (idx_ff == stat.run_cnt - 5'd1);
               if (cmd.last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         S_MINP: begin
            if (idx_ff < stat.proc_cnt) begin
               cmd.op = OP_MINP;
               idx_in = idx_ff + 5'd1;
            end else begin
               idx_in   = '0;
               state_in = S_MINS;
            end
         end
         S_MINS: begin
            if (idx_ff < stat.sig_cnt) begin
               cmd.op = OP_MINS;
               idx_in = idx_ff + 5'd1;
            end else begin
               state_in = S_ADVCHK;
            end
         end
         S_ADVCHK: begin
            if (stat.finished) begin
               cmd.op   = OP_EMIT_STATUS;
               cmd.code = ST_FINISHED;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_SET_NOW;
               state_in = S_DELTA0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         pass_ff  <= '0;
         w_ff     <= '0;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pass_ff  <= pass_in;
         w_ff     <= w_in;
         ret_ff   <= ret_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[sv/delta_cycle_event_scheduler.sv]
// Event scheduler for an event-driven logic simulator, kept in tables.
// Command channel: drive req_item and raise start; the item transfers at a
// rising edge with start high and busy low. Results come out on rsp_item,
// one per cycle, each marked by a single-cycle rsp_valid; the receiver
// cannot hold them off. last marks the final result of an item.
// Configuration: csr_data writes the stop time when csr_valid is high
// (csr_ready is always high); write only while busy is low.
// Table and query items latch the request, execute in the EXEC state and
// register their one result. Start, delta and advance walk the signal,
// map, waiter and process tables entry by entry (map spreading repeats
// while values move, up to 16 passes); advance first searches the
// process wake times and the pending signal times for the next time.
// The next item is taken in the cycle that carries the last result.
// Reset (synchronous, active high) empties all tables, zeroes time and
// loads the stop time with 50000000.
module delta_cycle_event_scheduler import dces_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   dces_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_action (req_item.action),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy)
   );

   dces_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTH
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> busy)
      else $error("result without last while idle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> !busy)
      else $error("still busy after last result");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("unexpected state after transfer");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_OK |-> rsp_item.last)
      else $error("error status not on final result");
`endif

endmodule
